>>> design/lpht_pkg.sv
package lpht_pkg;

   // operation codes
   localparam logic [2:0] FUNC_GET     = 3'd0;
   localparam logic [2:0] FUNC_PUT     = 3'd1;
   localparam logic [2:0] FUNC_REPLACE = 3'd2;
   localparam logic [2:0] FUNC_ADD     = 3'd3;
   localparam logic [2:0] FUNC_REMOVE  = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_HASH = 2'd2;

   localparam int unsigned COUNT_WIDTH = 11;
   localparam logic [COUNT_WIDTH-1:0] LOAD_LIMIT_RESET = 11'd768;

   // command from controller to datapath
   typedef struct packed {
      logic capture;   // latch request word, start at home bucket
      logic clear_adv; // advance clearing pointer
      logic read;      // issue slot read at probe pointer
      logic advance;   // step probe pointer
      logic commit;    // apply write and build result
   } lpht_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_done;
      logic bad_req;   // unused code or zero hash, no probe needed
      logic hit;       // read slot matches hash
      logic empty;     // read slot unreserved
      logic last;      // probe covered every slot
   } lpht_sts_type;

endpackage

>>> design/lpht_datapath.sv
module lpht_datapath
   import lpht_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpht_cmd_type           cmd,
   output lpht_sts_type           sts,
   input  logic [COUNT_WIDTH-1:0] load_limit,
   input  logic [2:0]             req_func,
   input  logic [63:0]            req_hash_high,
   input  logic [63:0]            req_hash_low,
   input  logic [63:0]            req_item_value,
   output logic                   res_found,
   output logic [63:0]            res_old_item,
   output logic                   res_added,
   output logic [1:0]             res_status,
   output logic [COUNT_WIDTH-1:0] res_live_count
);

   localparam int unsigned AW = $clog2(TABLE_SLOTS);

   // slot memories
   logic [63:0] mem_hh    [TABLE_SLOTS];
   logic [63:0] mem_hl    [TABLE_SLOTS];
   logic [63:0] mem_item  [TABLE_SLOTS];
   logic [63:0] mem_epoch [TABLE_SLOTS];

   logic [2:0]  func_ff;
   logic [63:0] hh_ff, hl_ff, item_ff;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW:0]   steps_ff, steps_in;
   logic [AW:0]   clr_ff;
   logic [63:0] rd_hh_ff, rd_hl_ff, rd_item_ff, rd_epoch_ff;
   logic [COUNT_WIDTH-1:0] reserved_ff, entry_ff;
   logic [63:0] epoch_ff;

   logic clearing;
   assign clearing = !clr_ff[AW];

   // probe pointer and step count
   always_comb begin
      ptr_in   = ptr_ff;
      steps_in = steps_ff;
      if (cmd.capture) begin
         ptr_in   = req_hash_low[AW-1:0];
         steps_in = '0;
      end else if (cmd.advance) begin
         ptr_in   = ptr_ff + 1'b1;
         steps_in = steps_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      steps_ff <= steps_in;
      if (cmd.capture) begin
         func_ff <= req_func;
         hh_ff   <= req_hash_high;
         hl_ff   <= req_hash_low;
         item_ff <= req_item_value;
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_adv && clearing) clr_ff <= clr_ff + 1'b1;
   end

   // status
   logic hit, live, empty;
   assign hit   = (rd_hh_ff == hh_ff) && (rd_hl_ff == hl_ff);
   assign empty = (rd_hh_ff == 64'd0) && (rd_hl_ff == 64'd0);
   assign live  = hit && (rd_epoch_ff != 64'd0);
   always_comb begin
      sts.clear_done = !clearing;
      sts.bad_req    = (func_ff > FUNC_REMOVE) || (hh_ff == 64'd0 && hl_ff == 64'd0);
      sts.hit        = hit;
      sts.empty      = empty;
      sts.last       = (steps_ff == (AW+1)'(TABLE_SLOTS - 1));
   end

   // commit decision
   logic is_ins, wr_hash, wr_item, wr_epoch, zero_epoch, full;
   logic [63:0] epoch_next;
   logic probed;
   assign probed = !sts.bad_req;
   always_comb begin
      is_ins     = (func_ff == FUNC_PUT) || (func_ff == FUNC_ADD);
      wr_hash    = 1'b0;
      wr_item    = 1'b0;
      wr_epoch   = 1'b0;
      zero_epoch = 1'b0;
      full       = 1'b0;
      if (probed) begin
         if (is_ins) begin
            if (live) begin
               wr_item = (func_ff == FUNC_PUT);
            end else if (hit) begin
               wr_item  = 1'b1;
               wr_epoch = 1'b1;
            end else if (!empty ||
                         ({1'b0, reserved_ff} + 12'd1 >= {1'b0, load_limit})) begin
               full = 1'b1;
            end else begin
               wr_hash  = 1'b1;
               wr_item  = 1'b1;
               wr_epoch = 1'b1;
            end
         end else if (func_ff == FUNC_REPLACE) begin
            wr_item = live;
         end else if (func_ff == FUNC_REMOVE) begin
            zero_epoch = live;
         end
      end
      epoch_next = (epoch_ff + 64'd1 == 64'd0) ? 64'd1 : epoch_ff + 64'd1;
   end

   // memory ports: one write, one registered read at the next probe pointer
   always_ff @(posedge clock) begin
      if (clearing) begin
         mem_hh[clr_ff[AW-1:0]]    <= '0;
         mem_hl[clr_ff[AW-1:0]]    <= '0;
         mem_epoch[clr_ff[AW-1:0]] <= '0;
      end else if (cmd.commit) begin
         if (wr_hash) begin
            mem_hh[ptr_ff] <= hh_ff;
            mem_hl[ptr_ff] <= hl_ff;
         end
         if (wr_epoch)   mem_epoch[ptr_ff] <= epoch_ff;
         if (zero_epoch) mem_epoch[ptr_ff] <= '0;
      end
      if (cmd.commit && wr_item) mem_item[ptr_ff] <= item_ff;
      if (cmd.read) begin
         rd_hh_ff    <= mem_hh[ptr_in];
         rd_hl_ff    <= mem_hl[ptr_in];
         rd_item_ff  <= mem_item[ptr_in];
         rd_epoch_ff <= mem_epoch[ptr_in];
      end
   end

   // counters and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         entry_ff    <= '0;
         epoch_ff    <= 64'd1;
      end else if (cmd.commit) begin
         if (wr_hash) reserved_ff <= reserved_ff + 1'b1;
         if (wr_epoch) begin
            entry_ff <= entry_ff + 1'b1;
            epoch_ff <= epoch_next;
         end
         if (zero_epoch) entry_ff <= entry_ff - 1'b1;
      end
   end

   always_comb begin
      res_found      = probed && live;
      res_old_item   = (probed && live) ? rd_item_ff : 64'd0;
      res_added      = wr_epoch && (func_ff == FUNC_ADD);
      res_status     = (func_ff > FUNC_REMOVE) ? STATUS_OK :
                       (!probed) ? STATUS_ZERO_HASH :
                       full ? STATUS_FULL : STATUS_OK;
      res_live_count = entry_ff;
      if (cmd.commit) begin
         if (wr_epoch)   res_live_count = entry_ff + 1'b1;
         if (zero_epoch) res_live_count = entry_ff - 1'b1;
      end
   end

endmodule

>>> design/lpht_control.sv
module lpht_control
   import lpht_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         out_free,
   output logic         out_load,
   input  lpht_sts_type sts,
   output lpht_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_adv = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.bad_req) begin
               state_in = ST_DONE;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.hit || sts.empty || sts.last) begin
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               cmd.read    = 1'b1;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               out_load   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

>>> design/linear_probe_hash_table.sv
// Flow: a request is accepted in IDLE; READ reads its home bucket and CHECK steps on through
// the slots until a hit, an empty slot or the last slot. A zero hash or an unused code goes
// from READ straight to DONE. DONE waits while a stalled result word holds the output register,
// then commits and loads the result word. One request at a time; the slot memory reads one slot
// a cycle, and the next request is accepted the cycle after commit. Reset: synchronous, active
// high; afterwards a clearing sweep empties the table, and no request is accepted until it ends.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int unsigned TABLE_SLOTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [COUNT_WIDTH-1:0] csr_load_limit,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_func,
   input  logic [63:0]            req_hash_high,
   input  logic [63:0]            req_hash_low,
   input  logic [63:0]            req_item_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_found,
   output logic [63:0]            rsp_old_item,
   output logic                   rsp_added,
   output logic [1:0]             rsp_status,
   output logic [COUNT_WIDTH-1:0] rsp_live_count
);

   lpht_cmd_type cmd;
   lpht_sts_type sts;
   logic [COUNT_WIDTH-1:0] load_limit_ff;
   logic out_load, out_free;
   logic res_found, res_added;
   logic [63:0] res_old_item;
   logic [1:0] res_status;
   logic [COUNT_WIDTH-1:0] res_live_count;

   // load limit register
   always_ff @(posedge clock) begin
      if (reset) load_limit_ff <= LOAD_LIMIT_RESET;
      else if (csr_write) load_limit_ff <= csr_load_limit;
   end

   lpht_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .out_free(out_free), .out_load(out_load), .sts(sts), .cmd(cmd)
   );

   lpht_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .load_limit(load_limit_ff),
      .req_func(req_func), .req_hash_high(req_hash_high), .req_hash_low(req_hash_low),
      .req_item_value(req_item_value), .res_found(res_found), .res_old_item(res_old_item),
      .res_added(res_added), .res_status(res_status), .res_live_count(res_live_count)
   );

   // output word register
   assign out_free = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (out_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      if (out_load) begin
         rsp_found      <= res_found;
         rsp_old_item   <= res_old_item;
         rsp_added      <= res_added;
         rsp_status     <= res_status;
         rsp_live_count <= res_live_count;
      end
   end

endmodule

>>> design/lpht_checker.sv
module lpht_checker
   import lpht_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_found,
   input logic [63:0]            rsp_old_item,
   input logic                   rsp_added,
   input logic [1:0]             rsp_status,
   input logic [COUNT_WIDTH-1:0] rsp_live_count
);

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_found, rsp_old_item, rsp_added, rsp_status, rsp_live_count}))
      else $error("stalled word changed");

   // no old item without a hit
   a_old: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_old_item == 64'd0)
      else $error("old item without hit");

   // add success only on ok and never with a hit
   a_added: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_added |-> !rsp_found && rsp_status == STATUS_OK)
      else $error("bad added flag");

   // rejected words carry no hit
   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO_HASH |-> !rsp_found && !rsp_added)
      else $error("rejected word shows hit");

endmodule

bind linear_probe_hash_table lpht_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_found(rsp_found), .rsp_old_item(rsp_old_item), .rsp_added(rsp_added),
   .rsp_status(rsp_status), .rsp_live_count(rsp_live_count)
);
